// ----- rtl/mts_pkg.sv -----
// mts_pkg: shared types, state codes and status codes of the min tracking stack
// no dependencies
`default_nettype none

package mts_pkg;

  localparam int VAL_W   = 32;
  localparam int ENTRY_W = 34;

  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_POP_EMPTY = 2'd1;
  localparam status_t STAT_PUSH_FULL = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam val_t VAL_NONE = '1;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  typedef struct packed {
    entry_t push_entry;
    val_t   push_min;
    val_t   pop_min;
  } codec_res_t;

endpackage

`default_nettype wire

// ----- rtl/min_tracking_stack.sv -----
// min_tracking_stack: lifo of signed words that reports its minimum, entries in one ram
// depends on mts_pkg and mts_codec
// push: never busy, result strobe in the cycle after start; pop leaving an entry:
// goes through ST_POP (busy there while the new top is read from the ram), then the
// result strobe is registered; other items never busy, strobe in the cycle after start.
// synchronous active-low reset empties the stack; ram contents are not cleared.
`default_nettype none

module min_tracking_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_func,
  input  wire mts_pkg::val_t in_push_value,
  output logic               out_strobe,
  output mts_pkg::val_t      out_top_value,
  output mts_pkg::val_t      out_min_value,
  output logic               out_is_empty,
  output mts_pkg::status_t   out_status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);
  localparam logic [CW-1:0] TWO_CNT  = CW'(2);

  mts_pkg::entry_t mem [STACK_DEPTH];

  mts_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  mts_pkg::val_t     min_r, min_nxt;
  mts_pkg::entry_t   top_r, top_nxt;
  mts_pkg::entry_t   rd_data_r;
  logic              out_strobe_r, out_strobe_nxt;
  mts_pkg::val_t     out_top_r, out_top_nxt;
  mts_pkg::val_t     out_min_r, out_min_nxt;
  logic              out_empty_r, out_empty_nxt;
  mts_pkg::status_t  out_status_r, out_status_nxt;

  logic              accept;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [CW-1:0]     raddr_cnt;
  mts_pkg::val_t     dec_min;
  mts_pkg::entry_t   dec_entry;
  mts_pkg::codec_res_t codec_res;
  mts_pkg::val_t     dec_top;

  assign accept    = start && !busy;
  assign mem_waddr = fill_r[AW-1:0];
  assign raddr_cnt = fill_r - TWO_CNT;
  assign mem_raddr = raddr_cnt[AW-1:0];
  assign dec_entry = (state_r == mts_pkg::ST_POP) ? rd_data_r : top_r;
  assign dec_min   = min_r;

  mts_codec u_codec (
    .first_push (fill_r == '0),
    .push_value (in_push_value),
    .cur_min    (min_r),
    .pop_entry  (top_r),
    .dec_entry  (dec_entry),
    .dec_min    (dec_min),
    .res        (codec_res),
    .dec_top    (dec_top)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept && in_func == mts_pkg::FUNC_POP && fill_r >= TWO_CNT) begin
          state_nxt = mts_pkg::ST_POP;
        end
      end
      mts_pkg::ST_POP: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy           = 1'b0;
    mem_we         = 1'b0;
    fill_nxt       = fill_r;
    min_nxt        = min_r;
    top_nxt        = top_r;
    out_strobe_nxt = 1'b0;
    out_top_nxt    = out_top_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == mts_pkg::FUNC_PUSH) begin
            out_strobe_nxt = 1'b1;
            out_empty_nxt  = 1'b0;
            if (fill_r == FULL_CNT) begin
              out_top_nxt    = dec_top;
              out_min_nxt    = min_r;
              out_status_nxt = mts_pkg::STAT_PUSH_FULL;
            end else begin
              mem_we         = 1'b1;
              top_nxt        = codec_res.push_entry;
              min_nxt        = codec_res.push_min;
              fill_nxt       = fill_r + ONE_CNT;
              out_top_nxt    = in_push_value;
              out_min_nxt    = codec_res.push_min;
              out_status_nxt = mts_pkg::STAT_DONE;
            end
          end else if (fill_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_top_nxt    = mts_pkg::VAL_NONE;
            out_min_nxt    = mts_pkg::VAL_NONE;
            out_empty_nxt  = 1'b1;
            out_status_nxt = mts_pkg::STAT_POP_EMPTY;
          end else if (fill_r == ONE_CNT) begin
            fill_nxt       = '0;
            out_strobe_nxt = 1'b1;
            out_top_nxt    = mts_pkg::VAL_NONE;
            out_min_nxt    = mts_pkg::VAL_NONE;
            out_empty_nxt  = 1'b1;
            out_status_nxt = mts_pkg::STAT_DONE;
          end else begin
            fill_nxt = fill_r - ONE_CNT;
            min_nxt  = codec_res.pop_min;
          end
        end
      end
      mts_pkg::ST_POP: begin
        busy           = 1'b1;
        top_nxt        = rd_data_r;
        out_strobe_nxt = 1'b1;
        out_top_nxt    = dec_top;
        out_min_nxt    = min_r;
        out_empty_nxt  = 1'b0;
        out_status_nxt = mts_pkg::STAT_DONE;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= codec_res.push_entry;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mts_pkg::ST_IDLE;
      fill_r       <= '0;
      min_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      min_r        <= min_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    out_top_r    <= out_top_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_top_value = out_top_r;
  assign out_min_value = out_min_r;
  assign out_is_empty  = out_empty_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond depth");

  a_pop_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mts_pkg::ST_POP) |-> $past(in_func == mts_pkg::FUNC_POP))
    else $error("pop read state without a pop");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == mts_pkg::FUNC_PUSH) |=> out_strobe)
    else $error("push gave no result word");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mts_pkg::ST_POP) |=> (out_strobe && !busy))
    else $error("pop read gave no result word");

  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_empty) |->
      (out_top_value == mts_pkg::VAL_NONE && out_min_value == mts_pkg::VAL_NONE))
    else $error("empty word with a value");
`endif

endmodule

`default_nettype wire

// ----- rtl/mts_codec.sv -----
// mts_codec: encodes a pushed word against the minimum, restores the minimum on pop
// and decodes a stored entry; depends on mts_pkg
`default_nettype none

module mts_codec (
  input  wire logic                first_push,
  input  wire mts_pkg::val_t       push_value,
  input  wire mts_pkg::val_t       cur_min,
  input  wire mts_pkg::entry_t     pop_entry,
  input  wire mts_pkg::entry_t     dec_entry,
  input  wire mts_pkg::val_t       dec_min,
  output mts_pkg::codec_res_t      res,
  output mts_pkg::val_t            dec_top
);

  mts_pkg::entry_t v_ext;
  mts_pkg::entry_t min_ext;
  mts_pkg::entry_t dec_min_ext;
  mts_pkg::entry_t restored;

  assign v_ext       = mts_pkg::entry_t'(push_value);
  assign min_ext     = mts_pkg::entry_t'(cur_min);
  assign dec_min_ext = mts_pkg::entry_t'(dec_min);
  assign restored    = (min_ext <<< 1) - pop_entry;

  always_comb begin
    if (first_push) begin
      res.push_entry = v_ext;
      res.push_min   = push_value;
    end else if (v_ext < min_ext) begin
      res.push_entry = (v_ext <<< 1) - min_ext;
      res.push_min   = push_value;
    end else begin
      res.push_entry = v_ext;
      res.push_min   = cur_min;
    end
    if (pop_entry < min_ext) begin
      res.pop_min = restored[mts_pkg::VAL_W-1:0];
    end else begin
      res.pop_min = cur_min;
    end
    if (dec_entry < dec_min_ext) begin
      dec_top = dec_min;
    end else begin
      dec_top = dec_entry[mts_pkg::VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire
